>>> src/assert_macros.svh
// Assertion macros shared by the RTL; defining ASSERT_OFF compiles them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/bca_pkg.sv
// Types and constants of the block chain allocator.
`timescale 1ns / 1ps
package bca_pkg;
	localparam int FILE_COUNT  = 16;
	localparam int BLOCK_COUNT = 128;
	localparam int BLOCK_BYTES = 512;
	localparam int FILE_W      = 4;
	localparam int BLK_W       = 7;
	localparam int OFF_W       = 9;
	localparam int SIZE_W      = 17;
	localparam int POS_W       = 16;
	localparam int STAT_W      = 3;
	localparam int FUNC_W      = 2;
	// File scan cursor and block scan cursor can both reach the table depth.
	localparam int FSCAN_W     = FILE_W + 1;
	localparam int BSCAN_W     = BLK_W + 1;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC     = 2'd0,
		FN_SET_SIZE  = 2'd1,
		FN_TRANSLATE = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_FILE  = 3'd1,
		ST_NO_BLOCK = 3'd2,
		ST_UNALLOC  = 3'd3,
		ST_BEYOND   = 3'd4
	} status_t;

	// One entry of the link memory: end-of-chain flag or the next block.
	typedef struct packed {
		logic             last;
		logic [BLK_W-1:0] next;
	} link_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FSCAN,
		S_BSCAN,
		S_GROW_RD,
		S_GROW_CHK,
		S_GROW_LINK,
		S_GROW_END,
		S_FREE_RD,
		S_FREE_CHK,
		S_WALK_RD,
		S_WALK_CHK,
		S_DONE
	} state_t;
endpackage

>>> src/bca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> src/block_chain_allocator.sv
// Top level of the block chain allocator: sequencer, tables and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block keeps sixteen file entries and a chain table of 128 blocks of 512 bytes, and
// takes one command item at a time: allocate, set size or translate; the spare code is a
// no-op. All work goes through a single sequencer around one link memory port (one read
// and one write per cycle, registered read data) and one block scan cursor that tests one
// free bit a cycle. Every item is accepted in idle and ends in the result stage. Allocate
// tests one file entry a cycle until it finds a free one or every entry is taken, then one
// block a cycle until it finds a free one or none is left. Set size walks the chain one
// link at a time, adds blocks found by the block scan, which only moves forward within an
// item, and on truncation frees the blocks past the new end one by one. Translate walks
// one link for each block index of the position. A result goes into an output register
// and the block returns to idle once that register is free; cmd_stall is high from
// acceptance until then. The tables come out of reset all free and all unallocated at
// once, as the free map and the file valid bits are flip-flops, so no clearing pass is
// needed.
module block_chain_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [bca_pkg::FUNC_W-1:0]   func,
	input  logic [bca_pkg::FILE_W-1:0]   file_id,
	input  logic [bca_pkg::SIZE_W-1:0]   size_bytes,
	input  logic [bca_pkg::POS_W-1:0]    byte_pos,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [bca_pkg::STAT_W-1:0]   status,
	output logic [bca_pkg::FILE_W-1:0]   file_index,
	output logic [bca_pkg::BLK_W-1:0]    block_number,
	output logic [bca_pkg::OFF_W-1:0]    block_offset
);
	localparam int WANT_W = bca_pkg::SIZE_W - bca_pkg::OFF_W + 1;

	bca_pkg::state_t  state_q, state_d;

	// Latched command.
	bca_pkg::func_t              func_q;
	logic [bca_pkg::BSCAN_W-1:0] target_q;
	logic [bca_pkg::OFF_W-1:0]   off_q;

	// Working registers.
	logic [bca_pkg::BLK_W-1:0]   bn_q, bn_d;
	logic [bca_pkg::BLK_W-1:0]   nxt_q, nxt_d;
	logic [bca_pkg::BSCAN_W-1:0] cnt_q, cnt_d;
	logic [bca_pkg::BSCAN_W-1:0] scan_q, scan_d;
	logic [bca_pkg::FSCAN_W-1:0] fscan_q, fscan_d;
	bca_pkg::status_t            stat_q, stat_d;

	// File table and free map.
	logic [bca_pkg::BLK_W-1:0]       fb_q [bca_pkg::FILE_COUNT];
	logic [bca_pkg::FILE_COUNT-1:0]  fb_valid_q;
	logic [bca_pkg::BLOCK_COUNT-1:0] free_q;

	// Result register.
	logic                        res_valid_q;
	logic [bca_pkg::STAT_W-1:0]  res_status_q;
	logic [bca_pkg::FILE_W-1:0]  res_file_index_q;
	logic [bca_pkg::BLK_W-1:0]   res_block_number_q;
	logic [bca_pkg::OFF_W-1:0]   res_block_offset_q;

	// Sequencer strobes.
	logic                      accept;
	logic                      res_load;
	logic                      scan_hit;
	logic                      alloc_hit;
	logic                      fb_we;
	logic                      free_clr;
	logic                      free_set;
	logic [bca_pkg::BLK_W-1:0] free_idx;
	logic                      ram_we;
	logic [bca_pkg::BLK_W-1:0] ram_waddr;
	bca_pkg::link_t            ram_wdata;
	logic [bca_pkg::BLK_W-1:0] ram_raddr;
	bca_pkg::link_t            ram_rdata;
	logic [$bits(bca_pkg::link_t)-1:0] ram_rdata_raw;

	// Block count needed for the requested size, rounded up and limited to the table.
	logic [bca_pkg::SIZE_W:0]    size_sum;
	logic [WANT_W-1:0]           want_full;
	logic [bca_pkg::BSCAN_W-1:0] want;

	assign size_sum  = {1'b0, size_bytes} + (bca_pkg::SIZE_W+1)'(bca_pkg::BLOCK_BYTES - 1);
	assign want_full = size_sum[bca_pkg::SIZE_W:bca_pkg::OFF_W];
	assign want      = (want_full > WANT_W'(bca_pkg::BLOCK_COUNT)) ?
		bca_pkg::BSCAN_W'(bca_pkg::BLOCK_COUNT) : want_full[bca_pkg::BSCAN_W-1:0];

	assign accept   = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != bca_pkg::S_IDLE);
	assign res_load = (state_q == bca_pkg::S_DONE) && (!res_valid_q || !res_stall);

	// The scan cursor points past the table once every block has been tested.
	assign scan_hit = (scan_q != bca_pkg::BSCAN_W'(bca_pkg::BLOCK_COUNT)) &&
		free_q[scan_q[bca_pkg::BLK_W-1:0]];
	// An allocate that has found both a file entry and a free block.
	assign alloc_hit = (state_q == bca_pkg::S_BSCAN) && (func_q == bca_pkg::FN_ALLOC) &&
		scan_hit;

	assign ram_rdata = bca_pkg::link_t'(ram_rdata_raw);

	bca_ram #(
		.WIDTH ($bits(bca_pkg::link_t)),
		.DEPTH (bca_pkg::BLOCK_COUNT)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, working register updates and table strobes.
	always_comb begin
		state_d   = state_q;
		bn_d      = bn_q;
		nxt_d     = nxt_q;
		cnt_d     = cnt_q;
		scan_d    = scan_q;
		fscan_d   = fscan_q;
		stat_d    = stat_q;
		fb_we     = 1'b0;
		free_clr  = 1'b0;
		free_set  = 1'b0;
		free_idx  = scan_q[bca_pkg::BLK_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = bn_q;
		ram_wdata = '{last: 1'b1, next: '0};
		ram_raddr = bn_q;

		unique case (state_q)
			bca_pkg::S_IDLE: begin
				if (accept) begin
					bn_d    = fb_q[file_id];
					cnt_d   = '0;
					scan_d  = '0;
					fscan_d = '0;
					stat_d  = bca_pkg::ST_OK;
					case (bca_pkg::func_t'(func))
						bca_pkg::FN_ALLOC: begin
							state_d = bca_pkg::S_FSCAN;
						end
						bca_pkg::FN_SET_SIZE: begin
							if (!fb_valid_q[file_id]) begin
								stat_d  = bca_pkg::ST_UNALLOC;
								state_d = bca_pkg::S_DONE;
							end else begin
								cnt_d   = bca_pkg::BSCAN_W'(1);
								state_d = bca_pkg::S_GROW_RD;
							end
						end
						bca_pkg::FN_TRANSLATE: begin
							if (!fb_valid_q[file_id]) begin
								stat_d  = bca_pkg::ST_UNALLOC;
								state_d = bca_pkg::S_DONE;
							end else if (byte_pos[bca_pkg::POS_W-1:bca_pkg::OFF_W] == '0) begin
								state_d = bca_pkg::S_DONE;
							end else begin
								state_d = bca_pkg::S_WALK_RD;
							end
						end
						default: begin
							state_d = bca_pkg::S_DONE;
						end
					endcase
				end
			end
			bca_pkg::S_FSCAN: begin
				if (fscan_q == bca_pkg::FSCAN_W'(bca_pkg::FILE_COUNT)) begin
					stat_d  = bca_pkg::ST_NO_FILE;
					state_d = bca_pkg::S_DONE;
				end else if (!fb_valid_q[fscan_q[bca_pkg::FILE_W-1:0]]) begin
					state_d = bca_pkg::S_BSCAN;
				end else begin
					fscan_d = fscan_q + bca_pkg::FSCAN_W'(1);
				end
			end
			bca_pkg::S_BSCAN: begin
				if (scan_q == bca_pkg::BSCAN_W'(bca_pkg::BLOCK_COUNT)) begin
					stat_d  = bca_pkg::ST_NO_BLOCK;
					state_d = bca_pkg::S_DONE;
				end else if (!scan_hit) begin
					scan_d = scan_q + bca_pkg::BSCAN_W'(1);
				end else if (func_q == bca_pkg::FN_ALLOC) begin
					fb_we     = 1'b1;
					free_clr  = 1'b1;
					ram_we    = 1'b1;
					ram_waddr = scan_q[bca_pkg::BLK_W-1:0];
					bn_d      = scan_q[bca_pkg::BLK_W-1:0];
					state_d   = bca_pkg::S_DONE;
				end else begin
					state_d = bca_pkg::S_GROW_LINK;
				end
			end
			bca_pkg::S_GROW_RD: begin
				state_d = bca_pkg::S_GROW_CHK;
			end
			bca_pkg::S_GROW_CHK: begin
				if (cnt_q >= target_q) begin
					// Chain is long enough: cut it here and free the rest.
					ram_we = 1'b1;
					if (!ram_rdata.last) begin
						nxt_d   = ram_rdata.next;
						state_d = bca_pkg::S_FREE_RD;
					end else begin
						state_d = bca_pkg::S_DONE;
					end
				end else if (!ram_rdata.last) begin
					bn_d    = ram_rdata.next;
					cnt_d   = cnt_q + bca_pkg::BSCAN_W'(1);
					state_d = bca_pkg::S_GROW_RD;
				end else begin
					state_d = bca_pkg::S_BSCAN;
				end
			end
			bca_pkg::S_GROW_LINK: begin
				free_clr  = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = '{last: 1'b0, next: scan_q[bca_pkg::BLK_W-1:0]};
				state_d   = bca_pkg::S_GROW_END;
			end
			bca_pkg::S_GROW_END: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q[bca_pkg::BLK_W-1:0];
				bn_d      = scan_q[bca_pkg::BLK_W-1:0];
				cnt_d     = cnt_q + bca_pkg::BSCAN_W'(1);
				state_d   = bca_pkg::S_GROW_RD;
			end
			bca_pkg::S_FREE_RD: begin
				ram_raddr = nxt_q;
				state_d   = bca_pkg::S_FREE_CHK;
			end
			bca_pkg::S_FREE_CHK: begin
				free_set = 1'b1;
				free_idx = nxt_q;
				if (!ram_rdata.last) begin
					nxt_d   = ram_rdata.next;
					state_d = bca_pkg::S_FREE_RD;
				end else begin
					state_d = bca_pkg::S_DONE;
				end
			end
			bca_pkg::S_WALK_RD: begin
				state_d = bca_pkg::S_WALK_CHK;
			end
			bca_pkg::S_WALK_CHK: begin
				if (ram_rdata.last) begin
					stat_d  = bca_pkg::ST_BEYOND;
					state_d = bca_pkg::S_DONE;
				end else begin
					bn_d  = ram_rdata.next;
					cnt_d = cnt_q + bca_pkg::BSCAN_W'(1);
					if (cnt_q + bca_pkg::BSCAN_W'(1) == target_q) begin
						state_d = bca_pkg::S_DONE;
					end else begin
						state_d = bca_pkg::S_WALK_RD;
					end
				end
			end
			bca_pkg::S_DONE: begin
				if (res_load) begin
					state_d = bca_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bca_pkg::S_IDLE;
			end
		endcase
	end

	// Working registers and the latched command carry no reset.
	always_ff @(posedge clk) begin
		bn_q    <= bn_d;
		nxt_q   <= nxt_d;
		cnt_q   <= cnt_d;
		scan_q  <= scan_d;
		fscan_q <= fscan_d;
		stat_q  <= stat_d;
		if (accept) begin
			func_q <= bca_pkg::func_t'(func);
			off_q  <= byte_pos[bca_pkg::OFF_W-1:0];
			if (bca_pkg::func_t'(func) == bca_pkg::FN_TRANSLATE) begin
				target_q <= {1'b0, byte_pos[bca_pkg::POS_W-1:bca_pkg::OFF_W]};
			end else begin
				target_q <= want;
			end
		end
		if (fb_we) begin
			fb_q[fscan_q[bca_pkg::FILE_W-1:0]] <= scan_q[bca_pkg::BLK_W-1:0];
		end
	end

	// The file valid bits and the free map are the reset state of the tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_valid_q <= '0;
			free_q     <= '1;
		end else begin
			if (fb_we) begin
				fb_valid_q[fscan_q[bca_pkg::FILE_W-1:0]] <= 1'b1;
			end
			if (free_clr) begin
				free_q[free_idx] <= 1'b0;
			end
			if (free_set) begin
				free_q[free_idx] <= 1'b1;
			end
		end
	end

	// Result register: fields without meaning for the operation are zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q       <= stat_q;
			res_file_index_q   <= '0;
			res_block_number_q <= '0;
			res_block_offset_q <= '0;
			if (stat_q == bca_pkg::ST_OK) begin
				if (func_q == bca_pkg::FN_ALLOC) begin
					res_file_index_q   <= fscan_q[bca_pkg::FILE_W-1:0];
					res_block_number_q <= bn_q;
				end else if (func_q == bca_pkg::FN_TRANSLATE) begin
					res_block_number_q <= bn_q;
					res_block_offset_q <= off_q;
				end
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = res_status_q;
	assign file_index   = res_file_index_q;
	assign block_number = res_block_number_q;
	assign block_offset = res_block_offset_q;

	// A finished item reaches the output register and the sequencer returns to idle.
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, res_load, res_valid_q && state_q == bca_pkg::S_IDLE)
	// A successful allocate claims exactly one more file entry.
	`ASSERT_NEXT(a_alloc_claims, clk, arst_n, alloc_hit, $countones(fb_valid_q) == $countones($past(fb_valid_q)) + 1)
	// A position past the chain reports no block and no offset.
	`ASSERT_IMPLY(a_beyond_zero, clk, arst_n, res_valid_q && res_status_q == bca_pkg::ST_BEYOND, res_block_number_q == '0 && res_block_offset_q == '0)
endmodule

>>> verif/chain_table_checker.sv
// Checker for the block chain allocator: keeps its own copy of the tables and compares results.
`timescale 1ns / 1ps
module chain_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  logic                       cmd_stall,
	input  logic [bca_pkg::FUNC_W-1:0] func,
	input  logic [bca_pkg::FILE_W-1:0] file_id,
	input  logic [bca_pkg::SIZE_W-1:0] size_bytes,
	input  logic [bca_pkg::POS_W-1:0]  byte_pos,
	input  logic                       res_valid,
	input  logic                       res_stall,
	input  logic [bca_pkg::STAT_W-1:0] status,
	input  logic [bca_pkg::FILE_W-1:0] file_index,
	input  logic [bca_pkg::BLK_W-1:0]  block_number,
	input  logic [bca_pkg::OFF_W-1:0]  block_offset,
	output int                         mismatch_count,
	output int                         pending_count,
	output int                         checked_count,
	output int                         command_count,
	output logic [4:0]                 codes_seen
);
	import bca_pkg::*;

	// Table markers: a free block and an unassigned file share one value.
	localparam int UNSET     = -1;
	localparam int CHAIN_END = -2;

	typedef struct packed {
		status_t           code;
		logic [FILE_W-1:0] file_no;
		logic [BLK_W-1:0]  blk;
		logic [OFF_W-1:0]  offset;
	} outcome_t;

	int       chain_next [BLOCK_COUNT];
	int       file_head [FILE_COUNT];
	outcome_t owed_results [$];
	int       errors;
	int       checked;
	int       commands;
	logic [4:0] seen;

	initial begin
		errors   = 0;
		checked  = 0;
		commands = 0;
		seen     = '0;
		codes_seen     = '0;
		mismatch_count = 0;
		pending_count  = 0;
		checked_count  = 0;
		command_count  = 0;
	end

	function automatic bit is_link(int v);
		return v >= 0 && v < BLOCK_COUNT;
	endfunction

	function automatic int lowest_free_block();
		int i;
		for (i = 0; i < BLOCK_COUNT; i++) begin
			if (chain_next[i] == UNSET) return i;
		end
		return UNSET;
	endfunction

	// Applies one command to the tables and returns the result it must produce.
	function automatic outcome_t apply_command(logic [FUNC_W-1:0] op, logic [FILE_W-1:0] fid,
			logic [SIZE_W-1:0] nbytes, logic [POS_W-1:0] pos);
		outcome_t r;
		int f, b, want, bn, n, nx, rel, i;
		bit failed, beyond;
		r = '0;
		r.code = ST_OK;
		case (op)
			FN_ALLOC: begin
				f = UNSET;
				for (i = 0; i < FILE_COUNT; i++) begin
					if (f == UNSET && !is_link(file_head[i])) f = i;
				end
				b = lowest_free_block();
				if (f == UNSET) begin
					r.code = ST_NO_FILE;
				end else if (b == UNSET) begin
					r.code = ST_NO_BLOCK;
				end else begin
					file_head[f]  = b;
					chain_next[b] = CHAIN_END;
					r.file_no     = FILE_W'(f);
					r.blk         = BLK_W'(b);
				end
			end
			FN_SET_SIZE: begin
				if (!is_link(file_head[fid])) begin
					r.code = ST_UNALLOC;
				end else begin
					want = int'((nbytes + BLOCK_BYTES - 1) / BLOCK_BYTES);
					if (want > BLOCK_COUNT) want = BLOCK_COUNT;
					bn     = file_head[fid];
					failed = 1'b0;
					for (i = 1; i < want && !failed; i++) begin
						if (chain_next[bn] == CHAIN_END) begin
							b = lowest_free_block();
							if (b == UNSET) begin
								failed = 1'b1;
							end else begin
								chain_next[bn] = b;
								chain_next[b]  = CHAIN_END;
							end
						end
						if (!failed) begin
							bn = chain_next[bn];
							if (!is_link(bn)) failed = 1'b1;
						end
					end
					if (failed) begin
						// Growth ran dry: the blocks added so far stay on the chain.
						r.code = ST_NO_BLOCK;
					end else begin
						n = chain_next[bn];
						chain_next[bn] = CHAIN_END;
						for (i = 0; i < BLOCK_COUNT && is_link(n); i++) begin
							nx = chain_next[n];
							chain_next[n] = UNSET;
							n = nx;
						end
					end
				end
			end
			FN_TRANSLATE: begin
				if (!is_link(file_head[fid])) begin
					r.code = ST_UNALLOC;
				end else begin
					rel    = int'(pos / BLOCK_BYTES);
					bn     = file_head[fid];
					beyond = rel >= BLOCK_COUNT;
					for (i = 0; i < rel && !beyond; i++) begin
						n = chain_next[bn];
						if (!is_link(n)) beyond = 1'b1;
						else bn = n;
					end
					if (beyond) begin
						r.code = ST_BEYOND;
					end else begin
						r.blk    = BLK_W'(bn);
						r.offset = OFF_W'(pos % BLOCK_BYTES);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic compare_field(string label, logic [8:0] exp_val, logic [8:0] act_val);
		if (act_val !== exp_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_val,
				act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t due;
		int k;
		if (!arst_n) begin
			for (k = 0; k < BLOCK_COUNT; k++) chain_next[k] = UNSET;
			for (k = 0; k < FILE_COUNT; k++) file_head[k] = UNSET;
			owed_results.delete();
		end else begin
			// A result never leaves in the cycle its command enters, so results go first.
			if (res_valid && !res_stall) begin
				if (owed_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected nothing, actual %0d/%0d/%0d/%0d",
						$time, status, file_index, block_number, block_offset);
				end else begin
					due = owed_results.pop_front();
					compare_field("status", 9'(due.code), 9'(status));
					compare_field("file_index", 9'(due.file_no), 9'(file_index));
					compare_field("block_number", 9'(due.blk), 9'(block_number));
					compare_field("block_offset", 9'(due.offset), 9'(block_offset));
					seen[due.code] = 1'b1;
					checked++;
				end
			end
			if (cmd_valid && !cmd_stall) begin
				owed_results.push_back(apply_command(func, file_id, size_bytes, byte_pos));
				commands++;
			end
		end
		mismatch_count <= errors;
		pending_count  <= owed_results.size();
		checked_count  <= checked;
		command_count  <= commands;
		codes_seen     <= seen;
	end
endmodule

>>> verif/testbench.sv
// Top of the block chain allocator testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import bca_pkg::*;

	// The two-bit operation field has one code that the block must treat as a no-op.
	localparam logic [FUNC_W-1:0] FN_RESERVED = 2'd3;

	localparam int RANDOM_COMMANDS = 1170;
	// Quiet cycles beyond the limit mean a hang; the limit has to cover the longest single
	// command with the long receiver hold-off and idle gaps on top.
	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_AT         = 150;
	localparam int HOLD_CYCLES     = 300;
	localparam int STEADY_FROM     = 500;
	localparam int STEADY_TO       = 700;
	localparam int DRAIN_CYCLES    = 50;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	logic [FUNC_W-1:0] func;
	logic [FILE_W-1:0] file_id;
	logic [SIZE_W-1:0] size_bytes;
	logic [POS_W-1:0]  byte_pos;
	logic              res_valid;
	logic              res_stall;
	logic [STAT_W-1:0] status;
	logic [FILE_W-1:0] file_index;
	logic [BLK_W-1:0]  block_number;
	logic [OFF_W-1:0]  block_offset;

	int         mismatch_count;
	int         pending_count;
	int         checked_count;
	int         command_count;
	logic [4:0] codes_seen;

	int idle_cycles   = 0;
	int results_taken = 0;
	bit sender_steady = 1'b0;

	block_chain_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.func         (func),
		.file_id      (file_id),
		.size_bytes   (size_bytes),
		.byte_pos     (byte_pos),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.file_index   (file_index),
		.block_number (block_number),
		.block_offset (block_offset)
	);

	chain_table_checker table_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.func           (func),
		.file_id        (file_id),
		.size_bytes     (size_bytes),
		.byte_pos       (byte_pos),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.status         (status),
		.file_index     (file_index),
		.block_number   (block_number),
		.block_offset   (block_offset),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count),
		.command_count  (command_count),
		.codes_seen     (codes_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Puts one command item on the channel and returns at the edge that accepts it.
	// Valid is only dropped for a random idle gap, never between back-to-back items,
	// and the payload only changes once the previous item has gone in.
	task automatic offer_command(input logic [FUNC_W-1:0] op, input logic [FILE_W-1:0] fid,
			input logic [SIZE_W-1:0] nbytes, input logic [POS_W-1:0] pos);
		while (!sender_steady && $urandom_range(99) < 6) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid  <= 1'b1;
		func       <= op;
		file_id    <= fid;
		size_bytes <= nbytes;
		byte_pos   <= pos;
		do @(posedge clk); while (cmd_stall);
	endtask

	// The watchdog ends the run if neither channel moves an item for too long; this
	// also catches expectations that never receive their result.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("testbench failed");
			$finish;
		end
	end

	// The result side stalls at random, except for a steady stretch, and once holds
	// off for a long while so that the block fills its output register and then
	// refuses further command items while the sender keeps offering them.
	initial begin : receiver
		bit held_off;
		held_off = 1'b0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) results_taken++;
			if (!held_off && results_taken == HOLD_AT) begin
				held_off = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (results_taken >= STEADY_FROM && results_taken < STEADY_TO) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(99) < 6);
			end
		end
	end

	initial begin : stimulus
		int k;
		int pick;
		int sel;
		logic [FUNC_W-1:0] op;
		logic [FILE_W-1:0] fid;
		logic [SIZE_W-1:0] nbytes;
		logic [POS_W-1:0]  pos;

		arst_n     <= 1'b0;
		cmd_valid  <= 1'b0;
		func       <= '0;
		file_id    <= '0;
		size_bytes <= '0;
		byte_pos   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset no file exists, so both chain operations must
		// report an unallocated file and change nothing.
		offer_command(FN_TRANSLATE, 4'd0, '0, '0);
		offer_command(FN_SET_SIZE, 4'd15, 17'd100, '0);
		// The spare operation code with every payload bit set must be a no-op.
		offer_command(FN_RESERVED, '1, '1, '1);
		// File 0 takes block 0; probe the last byte of its single block and the
		// first byte past the end of its chain.
		offer_command(FN_ALLOC, '0, '0, '0);
		offer_command(FN_TRANSLATE, 4'd0, '0, 16'd511);
		offer_command(FN_TRANSLATE, 4'd0, '0, 16'd512);
		// One byte over two blocks needs three; file 1 then gets block 3.
		offer_command(FN_SET_SIZE, 4'd0, 17'd1025, '0);
		offer_command(FN_ALLOC, '0, '0, '0);
		// The largest size asks for more blocks than exist: file 0 soaks up every
		// free block and still falls short, after which an allocation finds no block.
		offer_command(FN_SET_SIZE, 4'd0, '1, '0);
		offer_command(FN_ALLOC, '0, '0, '0);
		// The chain now holds 127 blocks: the top position lies past it, while the
		// last byte of block index 126 is still inside.
		offer_command(FN_TRANSLATE, 4'd0, '0, '1);
		offer_command(FN_TRANSLATE, 4'd0, '0, 16'd65023);
		// A size of zero still keeps one block and frees the rest of the chain.
		offer_command(FN_SET_SIZE, 4'd0, 17'd0, '0);
		// Fill every file entry; the last of these finds none left.
		repeat (FILE_COUNT - 1) offer_command(FN_ALLOC, '0, '0, '0);

		// Random part: mostly resizing and translating the sixteen live files, with
		// small sizes so that chains share the pool and now and then run it dry,
		// plus a few large sizes, stray allocations and the spare code as noise.
		for (k = 0; k < RANDOM_COMMANDS; k++) begin
			sender_steady = (k >= STEADY_FROM && k < STEADY_TO);
			fid  = FILE_W'($urandom_range(FILE_COUNT - 1));
			pick = $urandom_range(99);
			if (pick < 5) op = FN_ALLOC;
			else if (pick < 8) op = FN_RESERVED;
			else if (pick < 48) op = FN_SET_SIZE;
			else op = FN_TRANSLATE;

			sel = $urandom_range(99);
			if (sel < 65) begin
				nbytes = SIZE_W'($urandom_range(4095));
			end else if (sel < 85) begin
				nbytes = SIZE_W'($urandom_range(16383));
			end else if (sel < 93) begin
				// On or just either side of a block boundary.
				nbytes = SIZE_W'($urandom_range(BLOCK_COUNT) * BLOCK_BYTES
					+ $urandom_range(2) - 1);
			end else begin
				nbytes = SIZE_W'($urandom());
			end

			sel = $urandom_range(99);
			if (sel < 60) pos = POS_W'($urandom_range(4095));
			else if (sel < 85) pos = POS_W'($urandom_range(16383));
			else pos = POS_W'($urandom());

			offer_command(op, fid, nbytes, pos);
		end
		sender_steady = 1'b0;
		cmd_valid <= 1'b0;

		// Every command yields exactly one result, so once nothing is owed the block
		// is idle; a short drain catches any stray result.
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d command items sent, %0d results compared, %0d field mismatches.",
			command_count, checked_count, mismatch_count);
		$display("Status codes covered (beyond, unallocated, no block, no file, ok): %b",
			codes_seen);
		if (mismatch_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
